// ===== hdl/alamouti_zf_layer_demapper_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the layer demapper
// Shared concurrent assertion forms, clocked on clk and cut by rst.
// ---------------------------------------------------------------------------
`ifndef ALAMOUTI_ZF_LAYER_DEMAPPER_CORE_ASSERT_SVH
`define ALAMOUTI_ZF_LAYER_DEMAPPER_CORE_ASSERT_SVH

// same-cycle implication
`define AZF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AZF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/azf_pkg.sv =====
// ---------------------------------------------------------------------------
// azf_pkg
// Widths, codes, latencies and shared types of the layer demapper.
// ---------------------------------------------------------------------------
package azf_pkg;

  localparam int MAX_PORT_COUNT  = 4;
  localparam int MAX_LAYER_COUNT = 4;

  localparam int SAMPLE_W = 16;
  localparam int PRODUCT_W = 32;
  localparam int NUM_W    = 34;
  localparam int ABS_W    = 33;
  localparam int PWR_W    = 33;
  localparam int DEN_W    = 37;
  localparam int SCALED_W = 50;
  localparam int REM_W    = 54;
  localparam int QUO_W    = 17;
  localparam int SQRT2_W  = 17;
  localparam int SINGLE_SHIFT = 12;
  localparam int DIV_DEN_SHIFT = 4;

  localparam logic [SQRT2_W-1:0] SQRT2_Q16 = 17'd92682;

  localparam int FRONT_LAT = 3;
  localparam int DIV_STEPS = QUO_W;
  localparam int LANE_LAT  = DIV_STEPS + 4;
  localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_PORT_COUNT  = 2'd1;
  localparam logic [1:0] REG_LAYER_COUNT = 2'd2;

  localparam logic [1:0] MODE_SINGLE    = 2'd0;
  localparam logic [1:0] MODE_DIVERSITY = 2'd1;
  localparam logic [1:0] MODE_SPATIAL   = 2'd2;
  localparam logic [1:0] MODE_RESERVED  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CFG = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [NUM_W-1:0]    num_t;

  typedef struct packed {
    logic bad;
    logic last;
  } azf_entry_t;

  typedef struct packed {
    logic bad;
    logic zero;
    logic last;
  } azf_meta_t;

endpackage

// ===== hdl/alamouti_zf_layer_demapper_core.sv =====
// ---------------------------------------------------------------------------
// alamouti_zf_layer_demapper_core
// Zero-forcing single-antenna and Alamouti layer demapper, fully pipelined.
// ---------------------------------------------------------------------------
// Takes one pair of resource elements per clock and returns one result word
// per pair after three stages of products and sums, then four parallel lanes
// each holding a 17-stage restoring divider with scaling, overflow check and
// round/saturate stages around it. The whole pipeline stalls only while a
// finished word waits at the output and out_ready is low. Configuration
// writes are sampled as each word enters.
module alamouti_zf_layer_demapper_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [2:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       rx_even_re,
  input  logic signed [15:0]       rx_even_im,
  input  logic signed [15:0]       rx_odd_re,
  input  logic signed [15:0]       rx_odd_im,
  input  logic signed [15:0]       chan0_re,
  input  logic signed [15:0]       chan0_im,
  input  logic signed [15:0]       chan1_re,
  input  logic signed [15:0]       chan1_im,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [15:0]       layer0_re,
  output logic signed [15:0]       layer0_im,
  output logic signed [15:0]       layer1_re,
  output logic signed [15:0]       layer1_im,
  output logic [1:0]               status,
  output logic                     out_last
);

  `include "alamouti_zf_layer_demapper_core_assert.svh"

  localparam int LAT = azf_pkg::PIPE_LAT;

  logic [1:0] mode;
  logic [2:0] port_count;
  logic [2:0] layer_count;

  logic en;
  logic cfg_ok, cfg_single, cfg_div;
  logic [LAT-1:0] vld;

  azf_pkg::azf_entry_t entry_s [azf_pkg::FRONT_LAT];
  azf_pkg::azf_meta_t  meta_s  [azf_pkg::LANE_LAT];

  azf_pkg::num_t              num [4];
  logic [azf_pkg::DEN_W-1:0]  den;
  logic                       zero;
  logic                       div_f;
  azf_pkg::sample_t           res [4];
  logic [3:0]                 sat;
  azf_pkg::azf_meta_t         meta_out;
  logic                       kill;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= azf_pkg::MODE_SINGLE;
      port_count  <= 3'd1;
      layer_count <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        azf_pkg::REG_MODE:        mode        <= cfg_data[1:0];
        azf_pkg::REG_PORT_COUNT:  port_count  <= cfg_data;
        azf_pkg::REG_LAYER_COUNT: layer_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ok     = int'(port_count) <= azf_pkg::MAX_PORT_COUNT
                   && int'(layer_count) <= azf_pkg::MAX_LAYER_COUNT;
  assign cfg_single = cfg_ok && mode == azf_pkg::MODE_SINGLE
                   && port_count == 3'd1 && layer_count == 3'd1;
  assign cfg_div    = cfg_ok && mode == azf_pkg::MODE_DIVERSITY
                   && port_count == 3'd2 && layer_count == 3'd2;

  assign out_valid = vld[LAT-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry_s[0] <= '{bad: !(cfg_single || cfg_div), last: in_last};
      for (int i = 1; i < azf_pkg::FRONT_LAT; i++) entry_s[i] <= entry_s[i-1];
      meta_s[0] <= '{bad: entry_s[azf_pkg::FRONT_LAT-1].bad, zero: zero,
                     last: entry_s[azf_pkg::FRONT_LAT-1].last};
      for (int i = 1; i < azf_pkg::LANE_LAT; i++) meta_s[i] <= meta_s[i-1];
    end
  end

  azf_front u_front (
    .clk     (clk),
    .en      (en),
    .div     (cfg_div),
    .a       (rx_even_re),
    .b       (rx_even_im),
    .c       (rx_odd_re),
    .d       (rx_odd_im),
    .p       (chan0_re),
    .q       (chan0_im),
    .s       (chan1_re),
    .t       (chan1_im),
    .num     (num),
    .den     (den),
    .zero    (zero),
    .div_out (div_f)
  );

  for (genvar j = 0; j < 4; j++) begin : g_lane
    azf_lane u_lane (
      .clk (clk),
      .en  (en),
      .num (num[j]),
      .den (den),
      .div (div_f),
      .res (res[j]),
      .sat (sat[j])
    );
  end

  assign meta_out = meta_s[azf_pkg::LANE_LAT-1];
  assign kill     = meta_out.bad || meta_out.zero;

  assign layer0_re = kill ? '0 : res[0];
  assign layer0_im = kill ? '0 : res[1];
  assign layer1_re = kill ? '0 : res[2];
  assign layer1_im = kill ? '0 : res[3];
  assign out_last  = meta_out.last;

  always_comb begin
    priority if (meta_out.bad) status = azf_pkg::ST_BAD_CFG;
    else if (meta_out.zero)    status = azf_pkg::ST_ZERO;
    else if (|sat)             status = azf_pkg::ST_SAT;
    else                       status = azf_pkg::ST_OK;
  end

  `AZF_ASSERT_NOW(a_fault_zeroes, out_valid && (status == azf_pkg::ST_BAD_CFG || status == azf_pkg::ST_ZERO), layer0_re == 16'sd0 && layer0_im == 16'sd0 && layer1_re == 16'sd0 && layer1_im == 16'sd0, "fault word carries non-zero layers")
  `AZF_ASSERT_NOW(a_sat_clipped, out_valid && status == azf_pkg::ST_SAT, layer0_re == 16'sh7fff || layer0_re == -16'sh8000 || layer0_im == 16'sh7fff || layer0_im == -16'sh8000 || layer1_re == 16'sh7fff || layer1_re == -16'sh8000 || layer1_im == 16'sh7fff || layer1_im == -16'sh8000, "saturation flagged without clipped value")
  `AZF_ASSERT_NEXT(a_stall_holds, !en, $stable(vld) && $stable(meta_out), "pipeline moved during stall")

endmodule

// ===== hdl/azf_front.sv =====
// ---------------------------------------------------------------------------
// azf_front
// Products and sums: combiner numerators and channel power, three stages.
// ---------------------------------------------------------------------------
module azf_front (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       div,
  input  azf_pkg::sample_t           a,
  input  azf_pkg::sample_t           b,
  input  azf_pkg::sample_t           c,
  input  azf_pkg::sample_t           d,
  input  azf_pkg::sample_t           p,
  input  azf_pkg::sample_t           q,
  input  azf_pkg::sample_t           s,
  input  azf_pkg::sample_t           t,
  output azf_pkg::num_t              num [4],
  output logic [azf_pkg::DEN_W-1:0]  den,
  output logic                       zero,
  output logic                       div_out
);

  azf_pkg::sample_t a1, b1, c1, d1, p1, q1, s1, t1;
  logic div1, div2;
  logic signed [azf_pkg::PRODUCT_W-1:0] prod [16];
  logic signed [azf_pkg::PRODUCT_W-1:0] sq [4];
  logic [azf_pkg::PWR_W-1:0] pwr;

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a;
      b1   <= b;
      c1   <= c;
      d1   <= d;
      p1   <= p;
      q1   <= q;
      s1   <= div ? s : '0;
      t1   <= div ? t : '0;
      div1 <= div;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0]  <= p1 * a1;
      prod[1]  <= q1 * b1;
      prod[2]  <= s1 * c1;
      prod[3]  <= t1 * d1;
      prod[4]  <= p1 * b1;
      prod[5]  <= q1 * a1;
      prod[6]  <= t1 * c1;
      prod[7]  <= s1 * d1;
      prod[8]  <= p1 * c1;
      prod[9]  <= q1 * d1;
      prod[10] <= s1 * a1;
      prod[11] <= t1 * b1;
      prod[12] <= p1 * d1;
      prod[13] <= q1 * c1;
      prod[14] <= s1 * b1;
      prod[15] <= t1 * a1;
      sq[0]    <= p1 * p1;
      sq[1]    <= q1 * q1;
      sq[2]    <= s1 * s1;
      sq[3]    <= t1 * t1;
      div2     <= div1;
    end
  end

  assign pwr = azf_pkg::PWR_W'(unsigned'(sq[0])) + azf_pkg::PWR_W'(unsigned'(sq[1]))
             + azf_pkg::PWR_W'(unsigned'(sq[2])) + azf_pkg::PWR_W'(unsigned'(sq[3]));

  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= azf_pkg::NUM_W'(prod[0]) + azf_pkg::NUM_W'(prod[1])
              + azf_pkg::NUM_W'(prod[2]) + azf_pkg::NUM_W'(prod[3]);
      num[1] <= azf_pkg::NUM_W'(prod[4]) - azf_pkg::NUM_W'(prod[5])
              + azf_pkg::NUM_W'(prod[6]) - azf_pkg::NUM_W'(prod[7]);
      // layer 1 exists only in diversity mode
      num[2] <= div2 ? azf_pkg::NUM_W'(prod[8]) + azf_pkg::NUM_W'(prod[9])
                     - azf_pkg::NUM_W'(prod[10]) - azf_pkg::NUM_W'(prod[11]) : '0;
      num[3] <= div2 ? azf_pkg::NUM_W'(prod[12]) - azf_pkg::NUM_W'(prod[13])
                     + azf_pkg::NUM_W'(prod[14]) - azf_pkg::NUM_W'(prod[15]) : '0;
      den    <= div2 ? {pwr, azf_pkg::DIV_DEN_SHIFT'(0)}
                     : azf_pkg::DEN_W'(pwr);
      zero    <= (pwr == '0);
      div_out <= div2;
    end
  end

endmodule

// ===== hdl/azf_lane.sv =====
// ---------------------------------------------------------------------------
// azf_lane
// One output component: scale, radix-2 restoring divide, round and saturate.
// ---------------------------------------------------------------------------
module azf_lane (
  input  logic                       clk,
  input  logic                       en,
  input  azf_pkg::num_t              num,
  input  logic [azf_pkg::DEN_W-1:0]  den,
  input  logic                       div,
  output azf_pkg::sample_t           res,
  output logic                       sat
);

  localparam int STEPS = azf_pkg::DIV_STEPS;

  logic                          neg1, neg2;
  logic                          div1;
  logic [azf_pkg::ABS_W-1:0]     mag1;
  logic [azf_pkg::DEN_W-1:0]     den1, den2;
  logic [azf_pkg::SCALED_W-1:0]  x2;

  logic [azf_pkg::REM_W-1:0]     rem_s [STEPS+1];
  logic [azf_pkg::QUO_W-1:0]     quo_s [STEPS+1];
  logic [azf_pkg::DEN_W-1:0]     den_s [STEPS+1];
  logic                          neg_s [STEPS+1];
  logic                          ovf_s [STEPS+1];

  logic [azf_pkg::QUO_W-1:0]     q2;
  logic [azf_pkg::QUO_W:0]       qsum;
  logic [azf_pkg::QUO_W-1:0]     qr;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= num[azf_pkg::NUM_W-1];
      mag1 <= azf_pkg::ABS_W'(num[azf_pkg::NUM_W-1] ? -num : num);
      den1 <= den;
      div1 <= div;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2   <= div1 ? azf_pkg::SCALED_W'(mag1 * azf_pkg::SQRT2_Q16)
                   : azf_pkg::SCALED_W'({mag1, azf_pkg::SINGLE_SHIFT'(0)});
      den2 <= den1;
      neg2 <= neg1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= azf_pkg::REM_W'(x2);
      quo_s[0] <= '0;
      den_s[0] <= den2;
      neg_s[0] <= neg2;
      ovf_s[0] <= azf_pkg::REM_W'(x2) >= azf_pkg::REM_W'({den2, azf_pkg::QUO_W'(0)});
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = STEPS - 1 - k;
    logic [azf_pkg::REM_W-1:0] trial;
    logic                      take;

    assign trial = azf_pkg::REM_W'(den_s[k]) << BIT;
    assign take  = rem_s[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= take ? rem_s[k] - trial : rem_s[k];
        quo_s[k+1] <= quo_s[k] | (azf_pkg::QUO_W'(take) << BIT);
        den_s[k+1] <= den_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  assign q2   = ovf_s[STEPS] ? '1 : quo_s[STEPS];
  assign qsum = {1'b0, q2} + (azf_pkg::QUO_W+1)'(1);
  assign qr   = qsum[azf_pkg::QUO_W:1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_s[STEPS]) begin
        sat <= qr > azf_pkg::QUO_W'(32768);
        res <= (qr > azf_pkg::QUO_W'(32768)) ? azf_pkg::sample_t'(16'h8000)
                                             : azf_pkg::sample_t'(~qr[15:0] + 16'd1);
      end else begin
        sat <= qr > azf_pkg::QUO_W'(32767);
        res <= (qr > azf_pkg::QUO_W'(32767)) ? azf_pkg::sample_t'(16'h7fff)
                                             : azf_pkg::sample_t'(qr[15:0]);
      end
    end
  end

endmodule

// ===== tb/azf_checker.sv =====
// ---------------------------------------------------------------------------
// azf_checker
// Predicts each demapped word from the accepted input pair and compares it.
// ---------------------------------------------------------------------------
// Watches both channels and the register port at rising edges. It keeps its
// own copy of the registers, computes the expected layers with exact integer
// arithmetic, and queues them. Each output word is compared with the oldest
// queued prediction.
module azf_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [2:0]        cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic signed [15:0] rx_even_re,
  input  logic signed [15:0] rx_even_im,
  input  logic signed [15:0] rx_odd_re,
  input  logic signed [15:0] rx_odd_im,
  input  logic signed [15:0] chan0_re,
  input  logic signed [15:0] chan0_im,
  input  logic signed [15:0] chan1_re,
  input  logic signed [15:0] chan1_im,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic signed [15:0] layer0_re,
  input  logic signed [15:0] layer0_im,
  input  logic signed [15:0] layer1_re,
  input  logic signed [15:0] layer1_im,
  input  logic [1:0]        status,
  input  logic              out_last,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] l0r;
    logic signed [15:0] l0i;
    logic signed [15:0] l1r;
    logic signed [15:0] l1i;
    logic [1:0]         st;
    logic               last;
  } layer_word_t;

  layer_word_t expected_words[$];
  logic [1:0] mode_reg;
  logic [2:0] ports_reg;
  logic [2:0] layers_reg;

  function automatic logic signed [15:0] round_sat(longint n, longint d, ref bit clip);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    if (n < 0) begin
      if (q > 32768) begin
        clip = 1;
        return -16'sd32768;
      end
      return 16'(-q);
    end
    if (q > 32767) begin
      clip = 1;
      return 16'sd32767;
    end
    return 16'(q);
  endfunction

  function automatic layer_word_t demap_pair();
    layer_word_t w;
    longint a, b, c, d, p, q, s, t, pw, den;
    bit clip;
    bit lim_ok, single, diversity;
    a = longint'(rx_even_re); b = longint'(rx_even_im);
    c = longint'(rx_odd_re);  d = longint'(rx_odd_im);
    p = longint'(chan0_re);   q = longint'(chan0_im);
    s = longint'(chan1_re);   t = longint'(chan1_im);
    clip = 0;
    w = '0;
    w.last = in_last;
    lim_ok = ports_reg <= azf_pkg::MAX_PORT_COUNT && layers_reg <= azf_pkg::MAX_LAYER_COUNT;
    single = lim_ok && mode_reg == azf_pkg::MODE_SINGLE && ports_reg == 1 && layers_reg == 1;
    diversity = lim_ok && mode_reg == azf_pkg::MODE_DIVERSITY
             && ports_reg == 2 && layers_reg == 2;
    if (!single && !diversity) begin
      w.st = azf_pkg::ST_BAD_CFG;
    end else if (single) begin
      pw = p * p + q * q;
      if (pw == 0) w.st = azf_pkg::ST_ZERO;
      else begin
        w.l0r = round_sat((p * a + q * b) * 2048, pw, clip);
        w.l0i = round_sat((p * b - q * a) * 2048, pw, clip);
      end
    end else begin
      pw = p * p + q * q + s * s + t * t;
      if (pw == 0) w.st = azf_pkg::ST_ZERO;
      else begin
        den = pw * 32;
        w.l0r = round_sat((p * a + q * b + s * c + t * d) * 92682, den, clip);
        w.l0i = round_sat((p * b - q * a + t * c - s * d) * 92682, den, clip);
        w.l1r = round_sat((p * c + q * d - s * a - t * b) * 92682, den, clip);
        w.l1i = round_sat((p * d - q * c + s * b - t * a) * 92682, den, clip);
      end
    end
    if (w.st == azf_pkg::ST_OK && clip) w.st = azf_pkg::ST_SAT;
    return w;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    layer_word_t want, got;
    if (rst) begin
      mode_reg <= azf_pkg::MODE_SINGLE;
      ports_reg <= 3'd1;
      layers_reg <= 3'd1;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          azf_pkg::REG_MODE:        mode_reg <= cfg_data[1:0];
          azf_pkg::REG_PORT_COUNT:  ports_reg <= cfg_data;
          azf_pkg::REG_LAYER_COUNT: layers_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_words.push_back(demap_pair());
      if (out_valid && out_ready) begin
        got = '{layer0_re, layer0_im, layer1_re, layer1_im, status, out_last};
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("unexpected word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Alamouti layer demapper.
// ---------------------------------------------------------------------------
// Resets the block, runs phases under valid and invalid register settings
// with directed corner pairs then random pairs, with random idle bursts on
// both sides in all but the last phase, and reports the checker's result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = azf_pkg::REG_MODE;
  logic [2:0] cfg_data = '0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0, in_last = 0;
  logic signed [15:0] rx_even_re = 0, rx_even_im = 0, rx_odd_re = 0, rx_odd_im = 0;
  logic signed [15:0] chan0_re = 0, chan0_im = 0, chan1_re = 0, chan1_im = 0;
  logic signed [15:0] layer0_re, layer0_im, layer1_re, layer1_im;
  logic [1:0] status;
  logic out_last;
  int fail_count, pending, idle_cycles;
  bit quiet;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  alamouti_zf_layer_demapper_core dut (.*);
  azf_checker u_checker (.*);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("alamouti_zf_layer_demapper_core: mismatch");
      $finish;
    end
  end

  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        burst = $urandom_range(1, 3);
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1;
    end
  end

  function automatic logic signed [15:0] pick();
    case ($urandom_range(0, 7))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 0;
      3: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_pair(input logic signed [15:0] v[8], input logic lst);
    int burst;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      burst = $urandom_range(1, 3);
      repeat (burst) @(negedge clk);
    end
    in_valid <= 1;
    rx_even_re <= v[0]; rx_even_im <= v[1]; rx_odd_re <= v[2]; rx_odd_im <= v[3];
    chan0_re <= v[4]; chan0_im <= v[5]; chan1_re <= v[6]; chan1_im <= v[7];
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [1:0] md, input logic [2:0] pc, input logic [2:0] lc,
                           input int count);
    logic signed [15:0] v[8];
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (azf_pkg::PIPE_LAT + 4) @(negedge clk);
    write_reg(azf_pkg::REG_MODE, {1'b0, md});
    write_reg(azf_pkg::REG_PORT_COUNT, pc);
    write_reg(azf_pkg::REG_LAYER_COUNT, lc);
    for (int k = 0; k < count; k++) begin
      for (int j = 0; j < 8; j++) v[j] = pick();
      case (k)
        0: foreach (v[j]) v[j] = 0;
        1: foreach (v[j]) v[j] = -16'sd32768;
        2: foreach (v[j]) v[j] = 16'sd32767;
        3: begin foreach (v[j]) v[j] = 16'sd32767; v[4] = -16'sd32768; end
        4: begin v[4] = 0; v[5] = 0; v[6] = 0; v[7] = 0; end
        5: begin v[4] = 1; v[5] = 0; v[6] = 0; v[7] = 0; end
        6: begin v[4] = 0; v[5] = 0; v[6] = 0; v[7] = -1; end
        default: if ($urandom_range(0, 9) == 0) begin
          v[4] = 16'(int'($urandom_range(0, 3)) - 1); v[5] = 0; v[6] = 0; v[7] = 0;
        end
      endcase
      send_pair(v, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    idle_cycles = 0;
    quiet = 0;
    repeat (2) @(negedge clk);
    rst <= 0;
    run_phase(azf_pkg::MODE_SINGLE, 3'd1, 3'd1, 350);
    run_phase(azf_pkg::MODE_DIVERSITY, 3'd2, 3'd2, 450);
    run_phase(azf_pkg::MODE_SPATIAL, 3'd4, 3'd4, 20);
    run_phase(azf_pkg::MODE_RESERVED, 3'd7, 3'd7, 20);
    run_phase(azf_pkg::MODE_DIVERSITY, 3'd4, 3'd4, 20);
    run_phase(azf_pkg::MODE_SINGLE, 3'd2, 3'd1, 20);
    run_phase(azf_pkg::MODE_DIVERSITY, 3'd2, 3'd1, 20);
    run_phase(azf_pkg::MODE_SINGLE, 3'd0, 3'd0, 20);
    run_phase(azf_pkg::MODE_SINGLE, 3'd1, 3'd1, 200);
    quiet = 1;
    run_phase(azf_pkg::MODE_DIVERSITY, 3'd2, 3'd2, 250);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (azf_pkg::PIPE_LAT + 4) @(negedge clk);
    if (fail_count == 0) $display("alamouti_zf_layer_demapper_core: match");
    else $display("alamouti_zf_layer_demapper_core: mismatch");
    $finish;
  end
endmodule
